@@ rtl/core/rde_pkg.sv @@
// ============================================================================
// rde_pkg
// Shared types, field widths, codes and the digit glyph lookup for the
// radix digit emitter.
// ============================================================================
`default_nettype none

package rde_pkg;

    localparam int VALUE_W          = 64;
    localparam int RADIX_W          = 5;
    localparam int FORMAT_W         = 2;
    localparam int CHAR_W           = 7;
    localparam int DIGIT_W          = 4;
    localparam int NUMBER_WIDTH_DEF = 32;

    localparam int S_TDATA_W = 72;   // value, radix, format, zero pad
    localparam int M_TDATA_W = 8;    // character, zero pad

    localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 5'd16;
    localparam logic [RADIX_W-1:0] POINTER_RADIX = 5'd16;

    localparam logic CMD_NUMBER  = 1'b0;
    localparam logic CMD_POINTER = 1'b1;

    localparam logic [FORMAT_W-1:0] FMT_SIGNED         = 2'd0;
    localparam logic [FORMAT_W-1:0] FMT_UNSIGNED_LOWER = 2'd1;
    localparam logic [FORMAT_W-1:0] FMT_UNSIGNED_UPPER = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIV,
        ST_PRE0,
        ST_PRE1,
        ST_RD,
        ST_EMIT
    } rde_state_t;

    // Sequencer to divider
    typedef struct packed {
        logic               load;    // take a new dividend and start a pass
        logic               start;   // start a pass on the current quotient
        logic               wide;    // full 64-bit dividend
        logic [RADIX_W-1:0] base;
    } rde_div_req_t;

    // Divider to sequencer
    typedef struct packed {
        logic               done;    // pass finished this cycle
        logic [DIGIT_W-1:0] digit;   // remainder of the pass
        logic               zero;    // quotient left is zero
    } rde_div_rsp_t;

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d,
                                                      input logic upper);
        logic [CHAR_W-1:0] letter_base;
        letter_base = upper ? CHAR_UPPER : CHAR_LOWER;
        if (d < 4'd10)
            digit_glyph = CHAR_ZERO + {3'b000, d};
        else
            digit_glyph = letter_base + {3'b000, d - 4'd10};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rde_divider.sv @@
// ============================================================================
// rde_divider
// Iterative divider by a small base: eight dividend bits per cycle, one
// digit (remainder) per pass, quotient kept in place for the next pass.
// ============================================================================
`default_nettype none

module rde_divider #(
    parameter int NUMBER_WIDTH = rde_pkg::NUMBER_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rde_pkg::rde_div_req_t         req,
    input  wire logic [rde_pkg::VALUE_W-1:0]   load_value,
    output rde_pkg::rde_div_rsp_t              rsp
);
    import rde_pkg::*;

    localparam int NW_PAD        = ((NUMBER_WIDTH + 7) / 8) * 8;
    localparam int NARROW_CHUNKS = NW_PAD / 8;
    localparam int WIDE_CHUNKS   = VALUE_W / 8;
    localparam logic [VALUE_W-1:0] NARROW_MASK = {VALUE_W{1'b1}} >> (VALUE_W - NW_PAD);

    logic [VALUE_W-1:0] q_reg, q_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [RADIX_W-1:0] base_reg, base_next;
    logic               wide_reg, wide_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [7:0]         chunk;
    logic [7:0]         qbyte;
    logic [DIGIT_W-1:0] rem_step;
    logic [VALUE_W-1:0] shifted;

    // Restoring division over the top byte of the active window
    always_comb
    begin
        logic [4:0]         r;
        logic [DIGIT_W-1:0] rem_v;
        chunk = wide_reg ? q_reg[VALUE_W-1 -: 8] : q_reg[NW_PAD-1 -: 8];
        rem_v = rem_reg;
        qbyte = '0;
        for (int i = 7; i >= 0; i--)
        begin
            r = {rem_v, chunk[i]};
            if (r >= base_reg)
            begin
                r        = r - base_reg;
                qbyte[i] = 1'b1;
            end
            rem_v = r[DIGIT_W-1:0];
        end
        rem_step = rem_v;
        shifted  = {q_reg[VALUE_W-9:0], qbyte} & (wide_reg ? {VALUE_W{1'b1}} : NARROW_MASK);
    end

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        base_next = base_reg;
        wide_next = wide_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.load || req.start)
        begin
            if (req.load)
            begin
                q_next    = load_value;
                base_next = req.base;
                wide_next = req.wide;
            end
            busy_next = 1'b1;
            rem_next  = '0;
            cnt_next  = (req.load ? req.wide : wide_reg) ? 3'(WIDE_CHUNKS - 1)
                                                         : 3'(NARROW_CHUNKS - 1);
        end
        else if (busy_reg)
        begin
            q_next   = shifted;
            rem_next = rem_step;
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
        wide_reg <= wide_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.digit = rem_reg;
    assign rsp.zero  = (q_reg == '0);

endmodule

`default_nettype wire

@@ rtl/core/radix_digit_emitter.sv @@
// ============================================================================
// radix_digit_emitter
// Converts a number (base 2..16) or a 64-bit pointer to ASCII digits, most
// significant digit first, one output transaction per character.
// ============================================================================
// Division: each digit costs one divider pass over the number width, rounded
//   up to whole bytes, in number mode and over all 64 bits in pointer mode;
//   a 32-bit value in base 2 needs up to 32 passes.
// Emission: each character takes a digit memory read, then an output load;
//   in pointer mode the prefix characters 0x are emitted first.
// Throughput: one request at a time; the next is taken once the last
//   character sits in the output register. A bad base goes through the error state.
// Reset: rst_n is asynchronous, active low; clears the sequencer, digit
//   count and output valid. The digit memory holds no reset value.
// ============================================================================
`default_nettype none

module radix_digit_emitter #(
    parameter int NUMBER_WIDTH = rde_pkg::NUMBER_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Request stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [rde_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [63:0] value, [68:64] radix,
                                                                // [70:69] format, [71] zero
    input  wire logic                            s_axis_tuser,  // [0] cmd
    // Character stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [rde_pkg::M_TDATA_W-1:0]        m_axis_tdata,  // [6:0] character, [7] zero
    output logic                                 m_axis_tlast,  // last character
    output logic                                 m_axis_tuser   // [0] bad_base
);
    import rde_pkg::*;

    // Most digits any request can produce: base 2 of the number, or 16 hex
    // digits of a pointer.
    localparam int DEPTH  = (NUMBER_WIDTH > 16) ? NUMBER_WIDTH : 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [VALUE_W-1:0] NUM_MASK = {VALUE_W{1'b1}} >> (VALUE_W - NUMBER_WIDTH);

    // Request fields
    logic                in_cmd;
    logic [VALUE_W-1:0]  in_value;
    logic [RADIX_W-1:0]  in_radix;
    logic [FORMAT_W-1:0] in_format;
    logic                in_bad;
    logic [VALUE_W-1:0]  num_bits;
    logic [VALUE_W-1:0]  num_mag;

    assign in_cmd    = s_axis_tuser;
    assign in_value  = s_axis_tdata[VALUE_W-1:0];
    assign in_radix  = s_axis_tdata[VALUE_W +: RADIX_W];
    assign in_format = s_axis_tdata[VALUE_W+RADIX_W +: FORMAT_W];
    assign in_bad    = (in_cmd == CMD_NUMBER) && ((in_radix < RADIX_MIN) || (in_radix > RADIX_MAX));

    // Signed format with the sign bit set: convert the two's complement magnitude.
    // The most negative value wraps to itself, which is its unsigned magnitude.
    assign num_bits = in_value & NUM_MASK;
    assign num_mag  = ((in_format == FMT_SIGNED) && in_value[NUMBER_WIDTH-1])
                      ? ((~num_bits + {{(VALUE_W-1){1'b0}}, 1'b1}) & NUM_MASK)
                      : num_bits;

    // Sequencer state and registers
    rde_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ptr_reg, ptr_next;
    logic               upper_reg, upper_next;

    logic               m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]  m_char_reg, m_char_next;
    logic               m_last_reg, m_last_next;
    logic               m_bad_reg, m_bad_next;

    logic [DIGIT_W-1:0] store [DEPTH];
    logic [DIGIT_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic               store_we;

    logic               out_free;
    logic               accept;

    rde_div_req_t       div_req;
    rde_div_rsp_t       div_rsp;
    logic [VALUE_W-1:0] div_value;

    assign out_free = !m_valid_reg || m_axis_tready;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign wr_addr  = cnt_reg[ADDR_W-1:0];
    assign rd_addr  = ADDR_W'(cnt_reg - CNT_W'(1));

    rde_divider #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (div_req),
        .load_value (div_value),
        .rsp        (div_rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = in_bad ? ST_ERR : ST_DIV;
            end
            ST_ERR:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_rsp.done && div_rsp.zero)
                    state_next = ptr_reg ? ST_PRE0 : ST_RD;
            end
            ST_PRE0:
            begin
                if (out_free)
                    state_next = ST_PRE1;
            end
            ST_PRE1:
            begin
                if (out_free)
                    state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = (cnt_reg == CNT_W'(1)) ? ST_IDLE : ST_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs and register updates
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_req       = '0;
        div_value     = (in_cmd == CMD_POINTER) ? in_value : num_mag;
        store_we      = 1'b0;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        upper_next    = upper_reg;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;
        m_bad_next    = m_bad_reg;
        m_valid_next  = m_axis_tready ? 1'b0 : m_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (accept && !in_bad)
                begin
                    // Load the dividend and start the first pass
                    div_req.load  = 1'b1;
                    div_req.wide  = (in_cmd == CMD_POINTER);
                    div_req.base  = (in_cmd == CMD_POINTER) ? POINTER_RADIX : in_radix;
                    cnt_next      = '0;
                    ptr_next      = (in_cmd == CMD_POINTER);
                    upper_next    = (in_cmd == CMD_NUMBER) && (in_format == FMT_UNSIGNED_UPPER);
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_NUL;
                    m_last_next  = 1'b1;
                    m_bad_next   = 1'b1;
                end
            end
            ST_DIV:
            begin
                // Store each remainder, keep dividing until the quotient is zero
                if (div_rsp.done)
                begin
                    store_we = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (!div_rsp.zero)
                        div_req.start = 1'b1;
                end
            end
            ST_PRE0:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_ZERO;
                    m_last_next  = 1'b0;
                    m_bad_next   = 1'b0;
                end
            end
            ST_PRE1:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_X;
                    m_last_next  = 1'b0;
                    m_bad_next   = 1'b0;
                end
            end
            ST_RD:
            begin
                // Digit memory read in flight
            end
            ST_EMIT:
            begin
                // Emit digits in reverse order of discovery
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_char_next  = digit_glyph(rd_data_reg, upper_reg);
                    m_last_next  = (cnt_reg == CNT_W'(1));
                    m_bad_next   = 1'b0;
                    cnt_next     = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            ptr_reg     <= 1'b0;
            upper_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ptr_reg     <= ptr_next;
            upper_reg   <= upper_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload holds without reset
    always_ff @(posedge clk)
    begin
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        m_bad_reg  <= m_bad_next;
    end

    // Digit memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_we)
            store[wr_addr] <= div_rsp.digit;
        rd_data_reg <= store[rd_addr];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_char_reg};
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_bad_reg;

    // An error transaction is a single NUL character that closes the conversion
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("bad base transaction malformed");

    // The digit count never runs past the memory depth
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("digit count overflow");

    // The divider only finishes a pass while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider pass finished outside divide state");

    // Emission always follows a memory read
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> $past(state_reg) == ST_RD || $past(state_reg) == ST_EMIT)
        else $error("emit without digit read");

endmodule

`default_nettype wire
